@@ hdl/cpv_pkg.sv @@
package cpv_pkg;

  // Field formats
  localparam int STAT_FRAC_BITS    = 16;
  localparam int PROB_FRAC_BITS    = 16;
  localparam int STAT_W            = STAT_FRAC_BITS + 6;
  localparam int PROB_W            = PROB_FRAC_BITS + 1;
  localparam int COUNT_W           = 24;

  // Defaults for the top-level parameters
  localparam int CDF_TABLE_ENTRIES = 256;
  localparam int QUEUE_DEPTH       = 4;

  // Internal datapath formats (Q.24 fixed point)
  localparam int Q_FRAC   = 24;
  localparam int S_W      = STAT_W + Q_FRAC - STAT_FRAC_BITS;
  localparam int COEF_W   = 27;
  localparam int Z_W      = 34;
  localparam int LUT_FRAC = 28;

  // Region bounds on the statistic, Q.24
  localparam logic signed [S_W-1:0] TAU_MIN   = S_W'(-316418294);
  localparam logic signed [S_W-1:0] TAU_MAX   = S_W'(15435039);
  localparam logic signed [S_W-1:0] TAU_SPLIT = S_W'(-43956306);

  // Left-tail quadratic
  localparam logic signed [COEF_W-1:0] SQ_D0 = COEF_W'(48989471);
  localparam logic signed [COEF_W-1:0] SQ_D1 = COEF_W'(25185957);
  localparam logic signed [COEF_W-1:0] SQ_D2 = COEF_W'(667666);
  // Cubic for the rest
  localparam logic signed [COEF_W-1:0] CU_D0 = COEF_W'(36817601);
  localparam logic signed [COEF_W-1:0] CU_D1 = COEF_W'(10854020);
  localparam logic signed [COEF_W-1:0] CU_D2 = COEF_W'(-4898612);
  localparam logic signed [COEF_W-1:0] CU_D3 = COEF_W'(-710968);

  typedef enum logic [2:0] {
    CLS_CUBIC,
    CLS_QUAD,
    CLS_ZERO,
    CLS_ONE,
    CLS_ERR
  } cls_e;

  typedef struct packed {
    logic signed [STAT_W-1:0] test_statistic;
    logic [COUNT_W-1:0]       observation_count;
  } in_word_t;

  typedef struct packed {
    logic [PROB_W-1:0] p_value;
    logic              status;
  } out_word_t;

  typedef struct packed {
    cls_e                  cls;
    logic signed [S_W-1:0] stat;
  } work_t;

  // ---------------------------------------------------------------------
  // Elaboration-time arithmetic for the normal CDF table (64-bit, Q.62)
  // ---------------------------------------------------------------------
  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod >> s;
    return prod[63:0];
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // floor(num * 2^bits / den) for num < den
  function automatic logic [63:0] frac_div(input logic [63:0] num, input logic [63:0] den,
                                           input int unsigned bits);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = num;
    quo = '0;
    for (int unsigned i = 0; i < bits; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem    = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  localparam logic [63:0] ONE_Q62  = 64'd1 << 62;
  localparam logic [63:0] HALF_Q62 = 64'd1 << 61;

  // exp(-f) for f in [0, 1], both Q.62
  function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = ONE_Q62;
    term = ONE_Q62;
    for (int unsigned n = 1; n <= 40; n++) begin
      term = udiv64(mul_shr(term, f, 62), 64'(n));
      if (n[0]) acc = acc - term;
      else      acc = acc + term;
    end
    return acc;
  endfunction

  localparam logic [63:0] INV_SQRT_2PI =
      frac_div(64'd398942280401432678, 64'd1000000000000000000, 62);
  localparam logic [63:0] EXP_NEG_ONE = exp_neg_frac(ONE_Q62);

  // Entry k of the table: Phi(-8 + 16k/(entries-1)) in Q0.PROB_FRAC_BITS
  function automatic logic [PROB_W-1:0] cdf_entry(input int unsigned k,
                                                  input int unsigned entries);
    logic [63:0] den;
    logic [63:0] lhs;
    logic [63:0] rhs;
    logic        neg;
    logic [63:0] am;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] p;
    int unsigned i;
    int unsigned j;
    den = 64'(entries - 1);
    lhs = 64'(k) << 4;
    rhs = den << 3;
    neg = lhs < rhs;
    am  = neg ? rhs - lhs : lhs - rhs;
    quo = udiv64(am, den);
    rem = am - quo * den;
    x   = (quo << 58) | frac_div(rem, den, 58);
    x2  = mul_shr(x, x, 60);
    a   = mul_shr(x, x, 59);
    n   = a >> 58;
    e   = exp_neg_frac((a & ((64'd1 << 58) - 64'd1)) << 4);
    for (j = 0; j < n && j < 64; j++) begin
      e = mul_shr(e, EXP_NEG_ONE, 62);
    end
    term = mul_shr(mul_shr(e, INV_SQRT_2PI, 62), x, 58);
    sum  = term;
    for (i = 1; i < 4000 && term != 64'd0; i++) begin
      term = udiv64(term, 64'(2 * i + 1));
      term = mul_shr(term, x2, 56);
      sum  = sum + term;
    end
    if (sum > HALF_Q62) sum = HALF_Q62;
    p = neg ? HALF_Q62 - sum : HALF_Q62 + sum;
    p = (p + (64'd1 << (61 - PROB_FRAC_BITS))) >> (62 - PROB_FRAC_BITS);
    return p[PROB_W-1:0];
  endfunction

endpackage

@@ hdl/cpv_fifo.sv @@
module cpv_fifo #(
  parameter int  DEPTH  = cpv_pkg::QUEUE_DEPTH,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rd_ptr_q];

  // A full queue still takes a word when its head leaves in the same cycle
  assign do_pop  = pop_i && !empty_o;
  assign do_push = push_i && (!full_o || do_pop);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ hdl/cpv_front.sv @@
module cpv_front (
  input  logic                 push_i,
  output logic                 full_o,
  input  cpv_pkg::in_word_t    in_word_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output cpv_pkg::work_t       work_o
);

  logic signed [cpv_pkg::S_W-1:0] stat;

  assign full_o   = q_full_i;
  assign q_push_o = push_i && !q_full_i;

  // Bring the statistic to Q.24 and sort it into its region
  always_comb begin
    stat = cpv_pkg::S_W'(in_word_i.test_statistic)
           <<< (cpv_pkg::Q_FRAC - cpv_pkg::STAT_FRAC_BITS);
    work_o.stat = stat;
    if (in_word_i.observation_count < cpv_pkg::COUNT_W'(2)) begin
      work_o.cls = cpv_pkg::CLS_ERR;
    end else if (stat <= cpv_pkg::TAU_MIN) begin
      work_o.cls = cpv_pkg::CLS_ZERO;
    end else if (stat >= cpv_pkg::TAU_MAX) begin
      work_o.cls = cpv_pkg::CLS_ONE;
    end else if (stat <= cpv_pkg::TAU_SPLIT) begin
      work_o.cls = cpv_pkg::CLS_QUAD;
    end else begin
      work_o.cls = cpv_pkg::CLS_CUBIC;
    end
  end

endmodule

@@ hdl/cpv_cdf_rom.sv @@
module cpv_cdf_rom #(
  parameter int CDF_TABLE_ENTRIES = cpv_pkg::CDF_TABLE_ENTRIES
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic [$clog2(CDF_TABLE_ENTRIES)-1:0]   addr_lo_i,
  input  logic [$clog2(CDF_TABLE_ENTRIES)-1:0]   addr_hi_i,
  output logic [cpv_pkg::PROB_W-1:0]             data_lo_o,
  output logic [cpv_pkg::PROB_W-1:0]             data_hi_o
);

  logic [cpv_pkg::PROB_W-1:0] rom [CDF_TABLE_ENTRIES];
  logic [cpv_pkg::PROB_W-1:0] data_lo_q;
  logic [cpv_pkg::PROB_W-1:0] data_hi_q;

  for (genvar k = 0; k < CDF_TABLE_ENTRIES; k++) begin : g_entry
    localparam logic [cpv_pkg::PROB_W-1:0] VAL =
        cpv_pkg::cdf_entry(k, CDF_TABLE_ENTRIES);
    assign rom[k] = VAL;
  end

  // Two registered read ports: both ends of the interpolation interval
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_lo_q <= rom[addr_lo_i];
      data_hi_q <= rom[addr_hi_i];
    end
  end

  assign data_lo_o = data_lo_q;
  assign data_hi_o = data_hi_q;

endmodule

@@ hdl/cpv_back.sv @@
module cpv_back #(
  parameter int CDF_TABLE_ENTRIES = cpv_pkg::CDF_TABLE_ENTRIES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  cpv_pkg::work_t       in_work_i,
  output logic                 in_take_o,
  input  logic                 out_room_i,
  output logic                 out_push_o,
  output cpv_pkg::out_word_t   out_word_o
);

  localparam int S_W      = cpv_pkg::S_W;
  localparam int Z_W      = cpv_pkg::Z_W;
  localparam int Q_FRAC   = cpv_pkg::Q_FRAC;
  localparam int COEF_W   = cpv_pkg::COEF_W;
  localparam int PROB_W   = cpv_pkg::PROB_W;
  localparam int LUT_FRAC = cpv_pkg::LUT_FRAC;
  localparam int IDX_W    = $clog2(CDF_TABLE_ENTRIES);
  localparam int LOOK_W   = LUT_FRAC + IDX_W;
  localparam int STAGES   = 7;

  localparam int SS_W     = 2 * S_W;           // s*s
  localparam int P1_W     = COEF_W + S_W;      // linear term
  localparam int SQ_W     = SS_W - Q_FRAC;     // rounded square
  localparam int SQU_W    = 34;                // square bound in the quadratic region
  localparam int SQC_W    = 28;                // square bound in the cubic region
  localparam int P2_W     = COEF_W + SQU_W;
  localparam int PCU_W    = SQC_W + 1 + S_W;
  localparam int CU_W     = 32;
  localparam int P3_W     = COEF_W + CU_W;
  localparam int ACC_W    = PROB_W + LUT_FRAC + 1;
  localparam int HALF_Q   = 1 << (Q_FRAC - 1);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CDF_TABLE_ENTRIES - 1);
  localparam logic signed [Z_W-1:0] Z_POS8 = Z_W'(8 << Q_FRAC);
  localparam logic signed [Z_W-1:0] Z_NEG8 = -Z_POS8;
  localparam logic [PROB_W:0] P_ONE = (PROB_W + 1)'(1 << cpv_pkg::PROB_FRAC_BITS);

  logic               advance;
  logic [STAGES-1:0]  vld_q;

  // Stage 1: square and linear products
  cpv_pkg::cls_e             cls1_q;
  logic signed [S_W-1:0]     s1_q;
  logic signed [SS_W-1:0]    ss1_q;
  logic signed [P1_W-1:0]    p1_1_q;
  logic signed [COEF_W-1:0]  coef1;
  // Stage 2: quadratic-term and cube products
  cpv_pkg::cls_e             cls2_q;
  logic signed [P2_W-1:0]    p2_2_q;
  logic signed [PCU_W-1:0]   pcu2_q;
  logic signed [Z_W-1:0]     r1_2_q;
  logic signed [SS_W-1:0]    ss_rnd;
  logic signed [SQ_W-1:0]    sq;
  logic signed [P1_W-1:0]    p1_rnd;
  logic signed [COEF_W-1:0]  coef2;
  // Stage 3: cubic-term product
  cpv_pkg::cls_e             cls3_q;
  logic signed [P3_W-1:0]    p3_3_q;
  logic signed [Z_W-1:0]     r1_3_q;
  logic signed [Z_W-1:0]     r2_3_q;
  logic signed [PCU_W-1:0]   pcu_rnd;
  logic signed [CU_W-1:0]    cu;
  logic signed [P2_W-1:0]    p2_rnd;
  // Stage 4: z
  cpv_pkg::cls_e             cls4_q;
  logic signed [Z_W-1:0]     z4_q;
  logic signed [P3_W-1:0]    p3_rnd;
  logic signed [Z_W-1:0]     r3;
  logic signed [Z_W-1:0]     coef0;
  // Stage 5: table position
  cpv_pkg::cls_e             cls5_q;
  logic [LOOK_W-1:0]         u5_q;
  logic                      zlo5_q;
  logic                      zhi5_q;
  logic signed [Z_W-1:0]     z_off;
  // Stage 6: table read
  cpv_pkg::cls_e             cls6_q;
  logic [LUT_FRAC-1:0]       frac6_q;
  logic [IDX_W-1:0]          idx;
  logic                      sat_hi;
  logic [IDX_W-1:0]          addr_lo;
  logic [IDX_W-1:0]          addr_hi;
  logic [LUT_FRAC-1:0]       frac_eff;
  logic [PROB_W-1:0]         lo6;
  logic [PROB_W-1:0]         hi6;
  // Stage 7: interpolation product
  cpv_pkg::cls_e             cls7_q;
  logic [PROB_W-1:0]         lo7_q;
  logic [PROB_W+LUT_FRAC-1:0] prod7_q;
  logic [PROB_W-1:0]         diff;
  // Result
  logic [ACC_W-1:0]          acc;
  logic [PROB_W:0]           p_sum;
  logic [PROB_W:0]           p_sat;

  // Hold every stage while the last one cannot leave
  assign advance    = !(vld_q[STAGES-1] && !out_room_i);
  assign in_take_o  = advance && in_valid_i;
  assign out_push_o = vld_q[STAGES-1] && out_room_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[STAGES-2:0], in_valid_i};
    end
  end

  // Stage 1
  assign coef1 = (in_work_i.cls == cpv_pkg::CLS_QUAD) ? cpv_pkg::SQ_D1 : cpv_pkg::CU_D1;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cls1_q <= in_work_i.cls;
      s1_q   <= in_work_i.stat;
      ss1_q  <= in_work_i.stat * in_work_i.stat;
      p1_1_q <= coef1 * in_work_i.stat;
    end
  end

  // Stage 2
  always_comb begin
    ss_rnd = ss1_q + SS_W'(HALF_Q);
    sq     = ss_rnd[SS_W-1:Q_FRAC];
    p1_rnd = p1_1_q + P1_W'(HALF_Q);
    coef2  = (cls1_q == cpv_pkg::CLS_QUAD) ? cpv_pkg::SQ_D2 : cpv_pkg::CU_D2;
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cls2_q <= cls1_q;
      r1_2_q <= Z_W'($signed(p1_rnd[P1_W-1:Q_FRAC]));
      p2_2_q <= coef2 * $signed(sq[SQU_W-1:0]);
      pcu2_q <= $signed({1'b0, sq[SQC_W-1:0]}) * s1_q;
    end
  end

  // Stage 3
  always_comb begin
    pcu_rnd = pcu2_q + PCU_W'(HALF_Q);
    cu      = pcu_rnd[Q_FRAC+CU_W-1:Q_FRAC];
    p2_rnd  = p2_2_q + P2_W'(HALF_Q);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cls3_q <= cls2_q;
      r1_3_q <= r1_2_q;
      r2_3_q <= p2_rnd[Q_FRAC+Z_W-1:Q_FRAC];
      p3_3_q <= cpv_pkg::CU_D3 * cu;
    end
  end

  // Stage 4: drop the cubic term in the quadratic region
  always_comb begin
    p3_rnd = p3_3_q + P3_W'(HALF_Q);
    r3     = (cls3_q == cpv_pkg::CLS_CUBIC) ? p3_rnd[Q_FRAC+Z_W-1:Q_FRAC] : '0;
    coef0  = (cls3_q == cpv_pkg::CLS_QUAD) ? Z_W'(cpv_pkg::SQ_D0) : Z_W'(cpv_pkg::CU_D0);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cls4_q <= cls3_q;
      z4_q   <= coef0 + r1_3_q + r2_3_q + r3;
    end
  end

  // Stage 5: scale z+8 to table index units
  assign z_off = z4_q + Z_POS8;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cls5_q <= cls4_q;
      zlo5_q <= (z4_q <= Z_NEG8);
      zhi5_q <= (z4_q >= Z_POS8);
      u5_q   <= LOOK_W'(z_off[LUT_FRAC-1:0]) * LOOK_W'(CDF_TABLE_ENTRIES - 1);
    end
  end

  // Stage 6: pin to an end entry when z leaves the table span
  always_comb begin
    idx    = u5_q[LOOK_W-1:LUT_FRAC];
    sat_hi = zhi5_q || (idx >= LAST_IDX);
    if (zlo5_q) begin
      addr_lo  = '0;
      frac_eff = '0;
    end else if (sat_hi) begin
      addr_lo  = LAST_IDX;
      frac_eff = '0;
    end else begin
      addr_lo  = idx;
      frac_eff = u5_q[LUT_FRAC-1:0];
    end
    addr_hi = (addr_lo == LAST_IDX) ? LAST_IDX : addr_lo + 1'b1;
  end

  cpv_cdf_rom #(
    .CDF_TABLE_ENTRIES(CDF_TABLE_ENTRIES)
  ) u_cdf_rom (
    .clk_i    (clk_i),
    .en_i     (advance),
    .addr_lo_i(addr_lo),
    .addr_hi_i(addr_hi),
    .data_lo_o(lo6),
    .data_hi_o(hi6)
  );

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cls6_q  <= cls5_q;
      frac6_q <= frac_eff;
    end
  end

  // Stage 7
  assign diff = (hi6 < lo6) ? '0 : hi6 - lo6;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      cls7_q  <= cls6_q;
      lo7_q   <= lo6;
      prod7_q <= (PROB_W + LUT_FRAC)'(diff) * (PROB_W + LUT_FRAC)'(frac6_q);
    end
  end

  // Result: round the interpolation step, saturate at one, apply the region
  always_comb begin
    acc   = ACC_W'(prod7_q) + ACC_W'(1 << (LUT_FRAC - 1));
    p_sum = {1'b0, lo7_q} + acc[ACC_W-1:LUT_FRAC];
    p_sat = (p_sum > P_ONE) ? P_ONE : p_sum;
    out_word_o.status = 1'b0;
    case (cls7_q)
      cpv_pkg::CLS_ERR: begin
        out_word_o.p_value = '0;
        out_word_o.status  = 1'b1;
      end
      cpv_pkg::CLS_ZERO: begin
        out_word_o.p_value = '0;
      end
      cpv_pkg::CLS_ONE: begin
        out_word_o.p_value = P_ONE[PROB_W-1:0];
      end
      default: begin
        out_word_o.p_value = p_sat[PROB_W-1:0];
      end
    endcase
  end

endmodule

@@ hdl/cointegration_p_value_core.sv @@
// Channel   Direction  Handshake            Word
// --------  ---------  -------------------  -------------------------------------------
// input     in         push / full          in_word_i  : test_statistic, observation_count
// result    out        pop / empty          out_word_o : p_value, status
//
// Sustains one word per cycle in and out while pop stays high. A word passes the work queue,
// the seven back-end stages (square, polynomial products, z sum, table scaling, registered
// CDF table read, interpolation product) and the result queue write before it shows at the
// head of the result queue; it can be popped at the next edge. Reset clears queue pointers
// and stage valid bits; the CDF table is constant and needs no fill. With pop low and the
// result queue full, the back end holds; the work queue takes words until full rises.
module cointegration_p_value_core #(
  parameter int CDF_TABLE_ENTRIES = cpv_pkg::CDF_TABLE_ENTRIES,
  parameter int MID_DEPTH         = cpv_pkg::QUEUE_DEPTH,
  parameter int OUT_DEPTH         = cpv_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  cpv_pkg::in_word_t   in_word_i,
  output logic                empty,
  input  logic                pop,
  output cpv_pkg::out_word_t  out_word_o
);

  // Front to work queue
  logic               mid_push;
  logic               mid_full;
  cpv_pkg::work_t     mid_in;
  // Work queue to back end
  logic               mid_empty;
  logic               mid_pop;
  cpv_pkg::work_t     mid_out;
  // Back end to result queue
  logic               res_push;
  logic               res_full;
  logic               res_room;
  cpv_pkg::out_word_t res_in;

  // Classify each word as it arrives
  cpv_front u_front (
    .push_i   (push),
    .full_o   (full),
    .in_word_i(in_word_i),
    .q_full_i (mid_full),
    .q_push_o (mid_push),
    .work_o   (mid_in)
  );

  // Decouple the front from back-end stalls
  cpv_fifo #(
    .DEPTH (MID_DEPTH),
    .item_t(cpv_pkg::work_t)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .item_i (mid_in),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .empty_o(mid_empty),
    .item_o (mid_out)
  );

  // Polynomial, CDF lookup and interpolation
  cpv_back #(
    .CDF_TABLE_ENTRIES(CDF_TABLE_ENTRIES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(!mid_empty),
    .in_work_i (mid_out),
    .in_take_o (mid_pop),
    .out_room_i(res_room),
    .out_push_o(res_push),
    .out_word_o(res_in)
  );

  // A full result queue still has room when its head leaves this cycle
  assign res_room = !res_full || (pop && !empty);

  cpv_fifo #(
    .DEPTH (OUT_DEPTH),
    .item_t(cpv_pkg::out_word_t)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .item_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .empty_o(empty),
    .item_o (out_word_o)
  );

endmodule

@@ tb/tb_cointegration_p_value_core.sv @@
module tb_cointegration_p_value_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  // Settle time at the end, well past the push-to-head path.
  localparam int SETTLE_CYCLES = 32;
  localparam int PHI_ENTRIES  = cpv_pkg::CDF_TABLE_ENTRIES;

  localparam logic [63:0] ONE_Q62  = 64'd1 << 62;
  localparam logic [63:0] HALF_Q62 = 64'd1 << 61;
  localparam longint      P_ONE    = longint'(1) << cpv_pkg::PROB_FRAC_BITS;

  // Region bounds on the statistic in Q.24: -18.86, 0.92 and -2.62.
  localparam longint ZERO_AT_OR_BELOW = -316418294;
  localparam longint ONE_AT_OR_ABOVE  = 15435039;
  localparam longint QUAD_AT_OR_BELOW = -43956306;

  // Polynomial coefficients, round(c * 2^24).
  localparam longint LEFT_C0  = 48989471;
  localparam longint LEFT_C1  = 25185957;
  localparam longint LEFT_C2  = 667666;
  localparam longint MAIN_C0  = 36817601;
  localparam longint MAIN_C1  = 10854020;
  localparam longint MAIN_C2  = -4898612;
  localparam longint MAIN_C3  = -710968;

  localparam longint Z_SPAN   = longint'(8) << 24;

  typedef struct {
    cpv_pkg::in_word_t  word;
    cpv_pkg::out_word_t due;
  } p_value_due_t;

  // One directed word; known rows carry the answer typed in, the rest go
  // through the predictor.
  typedef struct {
    int stat;
    int count;
    bit known;
    int p;
    bit st;
  } directed_row_t;

  localparam int N_DIRECTED = 21;

  directed_row_t directed_tbl [N_DIRECTED] = '{
    // too few observations: status set, p-value zero
    '{0,        0,        1'b1, 0,     1'b1},
    '{0,        1,        1'b1, 0,     1'b1},
    '{2097151,  0,        1'b1, 0,     1'b1},
    '{-2097152, 1,        1'b1, 0,     1'b1},
    // field extremes: far left gives zero, far right gives one
    '{-2097152, 16777215, 1'b1, 0,     1'b0},
    '{2097151,  2,        1'b1, 65536, 1'b0},
    // left cut-off at -18.86: on it, then just above (z below -8)
    '{-1236009, 100,      1'b1, 0,     1'b0},
    '{-1236008, 100,      1'b0, 0,     1'b0},
    // right cut-off at 0.92: on it, then just below
    '{60294,    50,       1'b1, 65536, 1'b0},
    '{60293,    50,       1'b0, 0,     1'b0},
    // quadratic / cubic split at -2.62
    '{-171705,  30,       1'b0, 0,     1'b0},
    '{-171704,  30,       1'b0, 0,     1'b0},
    // assorted points of the curve
    '{0,        2,        1'b0, 0,     1'b0},
    '{-1,       3,        1'b0, 0,     1'b0},
    '{-65536,   1000,     1'b0, 0,     1'b0},
    '{-196608,  1000,     1'b0, 0,     1'b0},
    '{-655360,  1000,     1'b0, 0,     1'b0},
    '{-1200000, 7,        1'b0, 0,     1'b0},
    '{32768,    1000,     1'b0, 0,     1'b0},
    '{0,        16777215, 1'b0, 0,     1'b0},
    '{-131072,  8388608,  1'b0, 0,     1'b0}
  };

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               push    = 1'b0;
  logic               pop     = 1'b0;
  logic               full;
  logic               empty;
  cpv_pkg::in_word_t  in_word = '0;
  cpv_pkg::out_word_t out_word;

  logic [31:0]  phi_rom [PHI_ENTRIES];
  p_value_due_t pending_p_values [$];

  int   mismatches   = 0;
  int   cycle_count  = 0;
  int   send_idle_pct = 0;
  int   stall_pct    = 0;
  logic hold_active  = 1'b0;
  event hold_off_ev;

  cointegration_p_value_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_word_i  (in_word),
    .empty      (empty),
    .pop        (pop),
    .out_word_o (out_word)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Normal CDF table, rebuilt here in 64-bit Q.62 integer arithmetic
  // ---------------------------------------------------------------------

  // Full 128-bit product shifted right, low 64 bits kept.
  function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh);
    logic [127:0] wide;
    wide = {64'd0, a} * {64'd0, b};
    wide = wide >> sh;
    return wide[63:0];
  endfunction

  // floor(num * 2^bits / den), num < den
  function automatic logic [63:0] frac_q(input logic [63:0] num, input logic [63:0] den,
                                         input int unsigned bits);
    logic [127:0] wide;
    wide = {64'd0, num} << bits;
    wide = wide / {64'd0, den};
    return wide[63:0];
  endfunction

  // exp(-f), f and result in Q.62, 0 <= f <= 1; Taylor series through the f^40 term
  function automatic logic [63:0] exp_neg_q62(input logic [63:0] f);
    logic [63:0] acc;
    logic [63:0] term;
    acc  = ONE_Q62;
    term = ONE_Q62;
    for (int unsigned n = 1; n <= 40; n++) begin
      term = mul_shift(term, f, 62) / 64'(n);
      if (n % 2 == 1) acc = acc - term;
      else            acc = acc + term;
    end
    return acc;
  endfunction

  // Entry k holds Phi(-8 + 16k/(E-1)) rounded to Q0.PROB_FRAC_BITS.
  function automatic void build_phi_table();
    logic [63:0] den;
    logic [63:0] inv_root_2pi;
    logic [63:0] e_one;
    logic [63:0] am;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] half_sq;
    logic [63:0] whole;
    logic [63:0] e;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] p;
    longint      m;
    den          = 64'(PHI_ENTRIES - 1);
    inv_root_2pi = frac_q(64'd398942280401432678, 64'd1000000000000000000, 62);
    e_one        = exp_neg_q62(ONE_Q62);
    for (int k = 0; k < PHI_ENTRIES; k++) begin
      m  = 16 * longint'(k) - 8 * longint'(den);
      am = (m < 0) ? 64'(-m) : 64'(m);
      x  = ((am / den) << 58) | frac_q(am % den, den, 58);
      x2 = mul_shift(x, x, 60);
      half_sq = mul_shift(x, x, 59);
      whole   = half_sq >> 58;
      // split x^2/2 into integer and fraction: exp(-frac) * e^-1 per whole unit
      e = exp_neg_q62((half_sq & ((64'd1 << 58) - 64'd1)) << 4);
      for (int j = 0; j < whole && j < 64; j++) e = mul_shift(e, e_one, 62);
      term = mul_shift(mul_shift(e, inv_root_2pi, 62), x, 58);
      sum  = term;
      for (int i = 1; i < 4000 && term != 64'd0; i++) begin
        term = term / 64'(2 * i + 1);
        term = mul_shift(term, x2, 56);
        sum  = sum + term;
      end
      if (sum > HALF_Q62) sum = HALF_Q62;
      p = (m < 0) ? HALF_Q62 - sum : HALF_Q62 + sum;
      p = (p + (64'd1 << (61 - cpv_pkg::PROB_FRAC_BITS))) >> (62 - cpv_pkg::PROB_FRAC_BITS);
      phi_rom[k] = p[31:0];
    end
  endfunction

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Round a Q.48 product back to Q.24: add half, shift with floor.
  function automatic longint round_q24(input longint v);
    return (v + (longint'(1) <<< 23)) >>> 24;
  endfunction

  // Interpolated table read of Phi(z), z in Q.24.
  function automatic longint interp_phi(input longint z);
    longint u;
    longint idx;
    longint frac;
    longint lo;
    longint hi;
    if (z <= -Z_SPAN) return longint'(phi_rom[0]);
    if (z >= Z_SPAN)  return longint'(phi_rom[PHI_ENTRIES - 1]);
    u    = (z + Z_SPAN) * longint'(PHI_ENTRIES - 1);
    idx  = u >>> 28;
    frac = u & ((longint'(1) <<< 28) - 1);
    if (idx >= PHI_ENTRIES - 1) return longint'(phi_rom[PHI_ENTRIES - 1]);
    lo = longint'(phi_rom[idx]);
    hi = longint'(phi_rom[idx + 1]);
    if (hi < lo) hi = lo;
    return lo + (((hi - lo) * frac + (longint'(1) <<< 27)) >>> 28);
  endfunction

  function automatic cpv_pkg::out_word_t predict_p_value(input cpv_pkg::in_word_t w);
    cpv_pkg::out_word_t r;
    longint             s;
    longint             sq;
    longint             cu;
    longint             z;
    longint             p;
    r = '0;
    if (w.observation_count < 2) begin
      r.status = 1'b1;
      return r;
    end
    s = longint'($signed(w.test_statistic))
        * (longint'(1) <<< (24 - cpv_pkg::STAT_FRAC_BITS));
    if (s <= ZERO_AT_OR_BELOW) begin
      p = 0;
    end else if (s >= ONE_AT_OR_ABOVE) begin
      p = P_ONE;
    end else begin
      sq = round_q24(s * s);
      if (s <= QUAD_AT_OR_BELOW) begin
        z = LEFT_C0 + round_q24(LEFT_C1 * s) + round_q24(LEFT_C2 * sq);
      end else begin
        cu = round_q24(sq * s);
        z  = MAIN_C0 + round_q24(MAIN_C1 * s) + round_q24(MAIN_C2 * sq)
             + round_q24(MAIN_C3 * cu);
      end
      p = interp_phi(z);
      if (p > P_ONE) p = P_ONE;
    end
    r.p_value = cpv_pkg::PROB_W'(p);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic cpv_pkg::in_word_t random_word();
    cpv_pkg::in_word_t w;
    int unsigned       pick;
    int                stat;
    int                edge_pt;
    pick = $urandom_range(99);
    if (pick < 70) begin
      // the live curve between the two cut-offs, a little past each
      stat = int'($urandom_range(1296600)) - 1236200;
    end else if (pick < 85) begin
      // hug one of the three region bounds
      case ($urandom_range(2))
        0:       edge_pt = -1236009;
        1:       edge_pt = -171705;
        default: edge_pt = 60294;
      endcase
      stat = edge_pt + int'($urandom_range(1024)) - 512;
    end else begin
      // anything the field holds
      stat = int'($urandom());
    end
    w.test_statistic = cpv_pkg::STAT_W'(stat);
    // a few words with too few observations, the rest over the whole field
    if ($urandom_range(99) < 5) w.observation_count = cpv_pkg::COUNT_W'($urandom_range(1));
    else                         w.observation_count = cpv_pkg::COUNT_W'($urandom());
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // Offer one word and hold it until the block takes it, then log what the
  // result queue owes us. Push stays high across back-to-back words.
  task automatic send_word(input cpv_pkg::in_word_t w, input bit known,
                           input cpv_pkg::out_word_t typed);
    p_value_due_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    in_word <= w;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    entry.word = w;
    entry.due  = known ? typed : predict_p_value(w);
    pending_p_values.push_back(entry);
  endtask

  // Drop push and wait until every owed word has come back.
  task automatic wait_for_drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending_p_values.size() != 0);
  endtask

  task automatic run_random_phase(input int n_words, input int idle_pct, input int stall,
                                  input bit with_hold);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    for (int i = 0; i < n_words; i++) begin
      // long receiver hold-off while words keep coming: fill both queues
      if (with_hold && i == n_words / 3) -> hold_off_ev;
      send_word(random_word(), 1'b0, '0);
    end
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------
  // Receiver side
  // ---------------------------------------------------------------------

  // Random pop stalls; no pops at all while a hold-off runs.
  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else         pop <= !hold_active && ($urandom_range(99) >= stall_pct);
  end

  // Hold-off timer, counted here so the sender is free to keep pushing.
  initial begin
    forever begin
      @(hold_off_ev);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  // Compare each popped word with the oldest one owed.
  always @(posedge clk_i) begin
    p_value_due_t head;
    if (rst_ni && pop && !empty) begin
      if (pending_p_values.size() == 0) begin
        report_mismatch($sformatf("word with nothing owed: p_value %0d status %0d",
                                  out_word.p_value, out_word.status));
      end else begin
        head = pending_p_values.pop_front();
        if (out_word.p_value !== head.due.p_value)
          report_mismatch($sformatf("p_value stat %0d count %0d: got %0d want %0d",
                                    $signed(head.word.test_statistic),
                                    head.word.observation_count,
                                    out_word.p_value, head.due.p_value));
        if (out_word.status !== head.due.status)
          report_mismatch($sformatf("status stat %0d count %0d: got %0d want %0d",
                                    $signed(head.word.test_statistic),
                                    head.word.observation_count,
                                    out_word.status, head.due.status));
      end
    end
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    cpv_pkg::in_word_t  w;
    cpv_pkg::out_word_t typed;
    build_phi_table();

    // hold reset, then release on an edge
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words, no idling on either side
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int i = 0; i < N_DIRECTED; i++) begin
      w.test_statistic    = cpv_pkg::STAT_W'(directed_tbl[i].stat);
      w.observation_count = cpv_pkg::COUNT_W'(directed_tbl[i].count);
      typed.p_value       = cpv_pkg::PROB_W'(directed_tbl[i].p);
      typed.status        = directed_tbl[i].st;
      send_word(w, directed_tbl[i].known, typed);
    end
    wait_for_drain();

    // random words: full rate with a hold-off, then sender gaps,
    // receiver stalls, and both together
    run_random_phase(350, 0, 0, 1'b1);
    run_random_phase(350, 60, 0, 1'b0);
    run_random_phase(350, 0, 60, 1'b0);
    run_random_phase(300, 36, 36, 1'b0);

    // let any stray word surface before the verdict
    stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_p_values.size() != 0)
      report_mismatch($sformatf("%0d words never came back", pending_p_values.size()));

    if (mismatches == 0) $display("end of test: clean");
    else                 $display("end of test: mismatches");
    $finish;
  end

endmodule
